FILE: hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, types and constants of the 3x3 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int THR_W     = 31;
	localparam int NUM_ELEM  = 9;

	localparam int PROD_W    = 2 * ELEM_W;
	localparam int COF_W     = PROD_W + 1;
	localparam int PART_W    = COF_W;
	localparam int PSUM_W    = PART_W + 2;
	localparam int DET_W     = PSUM_W + ELEM_W;
	localparam int SCALE     = 2 * FRAC_BITS;
	localparam int DIV_STEPS = SCALE;

	// operand indices of each 2x2 cofactor: c = a[0]*a[1] - a[2]*a[3]
	localparam int COF_SEL [NUM_ELEM][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};
	// cofactors used in the row 0 expansion of the determinant
	localparam int DET_COF [3] = '{0, 3, 6};

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [THR_W-1:0] thr_t;

	localparam elem_t FIX_ONE = elem_t'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic [DET_W-1:0]     rem;
		logic [DIV_STEPS-1:0] quo;
		logic                 neg;
		logic                 ovf;
	} lane_t;

	typedef struct packed {
		lane_t [NUM_ELEM-1:0] lane;
		logic [DET_W-1:0]     dmag;
		logic                 singular;
	} div_item_t;

	typedef struct packed {
		elem_t [NUM_ELEM-1:0] elem;
		logic                 singular;
		logic                 saturated;
	} result_t;

endpackage

FILE: hw/rtl/mi3_div_pipe.sv
// ----------------------------------------------------------------------------
// mi3_div_pipe
// Pipelined restoring divider for the nine adjugate lanes: one quotient bit
// per stage, then rounding, clamping and the singular override.
// ----------------------------------------------------------------------------
module mi3_div_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mi3_pkg::div_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mi3_pkg::result_t    out_res
);

	typedef struct packed {
		logic [mi3_pkg::DIV_STEPS-1:0] quo;
		logic                          up;
		logic                          neg;
		logic                          ovf;
	} rnd_lane_t;

	typedef struct packed {
		rnd_lane_t [mi3_pkg::NUM_ELEM-1:0] lane;
		logic                              singular;
	} rnd_item_t;

	localparam logic [mi3_pkg::DIV_STEPS:0] LIM_NEG =
		(mi3_pkg::DIV_STEPS+1)'(65'd1 << (mi3_pkg::ELEM_W - 1));
	localparam logic [mi3_pkg::DIV_STEPS:0] LIM_POS = LIM_NEG - 1'b1;

	function automatic mi3_pkg::div_item_t div_step(input mi3_pkg::div_item_t d);
		mi3_pkg::div_item_t r;
		logic [mi3_pkg::DET_W:0] r2;
		logic [mi3_pkg::DET_W:0] diff;
		logic ge;
		r = d;
		for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
			r2   = {d.lane[i].rem, 1'b0};
			diff = r2 - {1'b0, d.dmag};
			ge   = (r2 >= {1'b0, d.dmag});
			r.lane[i].rem = ge ? diff[mi3_pkg::DET_W-1:0] : r2[mi3_pkg::DET_W-1:0];
			r.lane[i].quo = {d.lane[i].quo[mi3_pkg::DIV_STEPS-2:0], ge};
		end
		return r;
	endfunction

	// divider stages
	mi3_pkg::div_item_t          step_s     [1:mi3_pkg::DIV_STEPS];
	mi3_pkg::div_item_t          step_in    [1:mi3_pkg::DIV_STEPS];
	logic                        step_vld_s [1:mi3_pkg::DIV_STEPS];
	logic                        step_vld_in [1:mi3_pkg::DIV_STEPS];
	logic [mi3_pkg::DIV_STEPS+1:1] step_rdy;

	rnd_item_t rnd_s;
	logic      rnd_vld_s;
	logic      rnd_rdy;

	mi3_pkg::result_t out_q;
	mi3_pkg::result_t out_d;
	logic             out_vld_q;
	logic             out_rdy;

	assign out_rdy  = ~out_vld_q | out_ready;
	assign rnd_rdy  = ~rnd_vld_s | out_rdy;
	assign step_rdy[mi3_pkg::DIV_STEPS+1] = rnd_rdy;
	assign in_ready = step_rdy[1];
	assign step_in[1] = in_item;
	assign step_vld_in[1] = in_valid;

	genvar k;
	generate
		for (k = 1; k <= mi3_pkg::DIV_STEPS; k++) begin : g_step
			if (k > 1) begin : g_link
				assign step_in[k]     = step_s[k-1];
				assign step_vld_in[k] = step_vld_s[k-1];
			end
			assign step_rdy[k] = ~step_vld_s[k] | step_rdy[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_vld_s[k] <= 1'b0;
				end else if (step_rdy[k]) begin
					step_vld_s[k] <= step_vld_in[k];
				end
			end

			always_ff @(posedge clk) begin
				if (step_rdy[k]) begin
					step_s[k] <= div_step(step_in[k]);
				end
			end
		end
	endgenerate

	// rounding: half or more of the divisor left over rounds the magnitude up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s <= 1'b0;
		end else if (rnd_rdy) begin
			rnd_vld_s <= step_vld_s[mi3_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_rdy) begin
			rnd_s.singular <= step_s[mi3_pkg::DIV_STEPS].singular;
			for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
				rnd_s.lane[i].quo <= step_s[mi3_pkg::DIV_STEPS].lane[i].quo;
				rnd_s.lane[i].neg <= step_s[mi3_pkg::DIV_STEPS].lane[i].neg;
				rnd_s.lane[i].ovf <= step_s[mi3_pkg::DIV_STEPS].lane[i].ovf;
				rnd_s.lane[i].up  <= ({step_s[mi3_pkg::DIV_STEPS].lane[i].rem, 1'b0} >=
					{1'b0, step_s[mi3_pkg::DIV_STEPS].dmag});
			end
		end
	end

	// clamp, apply sign, or substitute identity
	always_comb begin
		logic [mi3_pkg::DIV_STEPS:0] qr;
		logic [mi3_pkg::DIV_STEPS:0] lim;
		logic [mi3_pkg::DIV_STEPS:0] mag;
		logic                        sat;
		logic                        any_sat;
		any_sat = 1'b0;
		out_d   = '0;
		for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
			qr  = {1'b0, rnd_s.lane[i].quo} + {{mi3_pkg::DIV_STEPS{1'b0}}, rnd_s.lane[i].up};
			lim = rnd_s.lane[i].neg ? LIM_NEG : LIM_POS;
			sat = rnd_s.lane[i].ovf | (qr > lim);
			mag = sat ? lim : qr;
			any_sat = any_sat | sat;
			if (rnd_s.singular) begin
				out_d.elem[i] = (i % 4 == 0) ? mi3_pkg::FIX_ONE : '0;
			end else if (rnd_s.lane[i].neg) begin
				out_d.elem[i] = ~mag[mi3_pkg::ELEM_W-1:0] + 1'b1;
			end else begin
				out_d.elem[i] = mag[mi3_pkg::ELEM_W-1:0];
			end
		end
		out_d.singular  = rnd_s.singular;
		out_d.saturated = any_sat & ~rnd_s.singular;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_rdy) begin
			out_vld_q <= rnd_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;

`ifndef SYNTHESIS
	a_sing_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.singular |-> !out_q.saturated)
		else $error("singular result flagged saturated");

	a_sing_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.singular |->
		out_q.elem[0] == mi3_pkg::FIX_ONE && out_q.elem[1] == '0 &&
		out_q.elem[8] == mi3_pkg::FIX_ONE)
		else $error("singular result is not identity");

	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_vld_s[1] && !step_rdy[2] |=> step_vld_s[1] && $stable(step_s[1]))
		else $error("stalled divider stage lost its item");
`endif

endmodule

FILE: hw/rtl/mat3_inverse_top.sv
// ----------------------------------------------------------------------------
// mat3_inverse_top
// Pipeline: 41 register stages (7 front stages, 32 divider stages, rounding
// and output register) between input transfer and result valid.
// Throughput: one matrix per cycle while out_ready is not held low; every stage stalls on its own.
// Reset: arst_n clears all valid bits and sets the singular threshold thr_q to 1.
// 3x3 Q16.16 inverse through the adjugate and an exact rounded division.
// ----------------------------------------------------------------------------
module mat3_inverse_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  mi3_pkg::thr_t   cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  mi3_pkg::elem_t  r0c0,
	input  mi3_pkg::elem_t  r0c1,
	input  mi3_pkg::elem_t  r0c2,
	input  mi3_pkg::elem_t  r1c0,
	input  mi3_pkg::elem_t  r1c1,
	input  mi3_pkg::elem_t  r1c2,
	input  mi3_pkg::elem_t  r2c0,
	input  mi3_pkg::elem_t  r2c1,
	input  mi3_pkg::elem_t  r2c2,
	output logic            out_valid,
	input  logic            out_ready,
	output mi3_pkg::elem_t  inv_r0c0,
	output mi3_pkg::elem_t  inv_r0c1,
	output mi3_pkg::elem_t  inv_r0c2,
	output mi3_pkg::elem_t  inv_r1c0,
	output mi3_pkg::elem_t  inv_r1c1,
	output mi3_pkg::elem_t  inv_r1c2,
	output mi3_pkg::elem_t  inv_r2c0,
	output mi3_pkg::elem_t  inv_r2c1,
	output mi3_pkg::elem_t  inv_r2c2,
	output logic            singular,
	output logic            saturated
);

	mi3_pkg::thr_t  thr_q;
	mi3_pkg::elem_t a [mi3_pkg::NUM_ELEM];

	logic signed [mi3_pkg::PROD_W-1:0] prod_s1 [mi3_pkg::NUM_ELEM][2];
	mi3_pkg::elem_t                    row0_s1 [3];
	logic signed [mi3_pkg::COF_W-1:0]  cof_s2  [mi3_pkg::NUM_ELEM];
	mi3_pkg::elem_t                    row0_s2 [3];
	logic signed [mi3_pkg::PART_W-1:0] lo_s3   [3];
	logic signed [mi3_pkg::PART_W-1:0] hi_s3   [3];
	logic signed [mi3_pkg::COF_W-1:0]  cof_s3  [mi3_pkg::NUM_ELEM];
	logic signed [mi3_pkg::PSUM_W-1:0] losum_s4;
	logic signed [mi3_pkg::PSUM_W-1:0] hisum_s4;
	logic signed [mi3_pkg::COF_W-1:0]  cof_s4  [mi3_pkg::NUM_ELEM];
	logic signed [mi3_pkg::DET_W-1:0]  det_s5;
	logic signed [mi3_pkg::COF_W-1:0]  cof_s5  [mi3_pkg::NUM_ELEM];
	logic [mi3_pkg::DET_W-1:0]         dmag_s6;
	logic [mi3_pkg::COF_W-1:0]         cmag_s6 [mi3_pkg::NUM_ELEM];
	logic [mi3_pkg::NUM_ELEM-1:0]      neg_s6;
	mi3_pkg::div_item_t                item_s7;
	logic [mi3_pkg::DET_W-1:0]         thr_ext;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;
	logic div_ready;

	mi3_pkg::result_t res;

	assign a[0] = r0c0;
	assign a[1] = r0c1;
	assign a[2] = r0c2;
	assign a[3] = r1c0;
	assign a[4] = r1c1;
	assign a[5] = r1c2;
	assign a[6] = r2c0;
	assign a[7] = r2c1;
	assign a[8] = r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::thr_t'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// threshold is an unsigned Q15.16 magnitude, det carries 3*FRAC_BITS fraction bits
	assign thr_ext = {{(mi3_pkg::DET_W - mi3_pkg::THR_W - mi3_pkg::SCALE){1'b0}},
		thr_q, {mi3_pkg::SCALE{1'b0}}};

	assign adv_s7   = ~valid_s7 | div_ready;
	assign adv_s6   = ~valid_s6 | adv_s7;
	assign adv_s5   = ~valid_s5 | adv_s6;
	assign adv_s4   = ~valid_s4 | adv_s5;
	assign adv_s3   = ~valid_s3 | adv_s4;
	assign adv_s2   = ~valid_s2 | adv_s3;
	assign adv_s1   = ~valid_s1 | adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
		end
	end

	// s1: the eighteen 2x2 products
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
				prod_s1[i][0] <= a[mi3_pkg::COF_SEL[i][0]] * a[mi3_pkg::COF_SEL[i][1]];
				prod_s1[i][1] <= a[mi3_pkg::COF_SEL[i][2]] * a[mi3_pkg::COF_SEL[i][3]];
			end
			for (int j = 0; j < 3; j++) begin
				row0_s1[j] <= a[j];
			end
		end
	end

	// s2: cofactors
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
				cof_s2[i] <= $signed({prod_s1[i][0][mi3_pkg::PROD_W-1], prod_s1[i][0]}) -
					$signed({prod_s1[i][1][mi3_pkg::PROD_W-1], prod_s1[i][1]});
			end
			row0_s2 <= row0_s1;
		end
	end

	// s3: row 0 times cofactor, split into low and high halves of the cofactor
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			for (int t = 0; t < 3; t++) begin
				lo_s3[t] <= row0_s2[t] *
					$signed({1'b0, cof_s2[mi3_pkg::DET_COF[t]][mi3_pkg::ELEM_W-1:0]});
				hi_s3[t] <= row0_s2[t] *
					$signed(cof_s2[mi3_pkg::DET_COF[t]][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// s4: partial sums
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			losum_s4 <= lo_s3[0] + lo_s3[1] + lo_s3[2];
			hisum_s4 <= hi_s3[0] + hi_s3[1] + hi_s3[2];
			cof_s4   <= cof_s3;
		end
	end

	// s5: determinant
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			det_s5 <= $signed({hisum_s4, {mi3_pkg::ELEM_W{1'b0}}}) + losum_s4;
			cof_s5 <= cof_s4;
		end
	end

	// s6: magnitudes and result signs
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			dmag_s6 <= det_s5[mi3_pkg::DET_W-1] ? (~det_s5 + 1'b1) : det_s5;
			for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
				cmag_s6[i] <= cof_s5[i][mi3_pkg::COF_W-1] ? (~cof_s5[i] + 1'b1) : cof_s5[i];
				neg_s6[i]  <= cof_s5[i][mi3_pkg::COF_W-1] ^ det_s5[mi3_pkg::DET_W-1];
			end
		end
	end

	// s7: singular test, divider seed; |cof| >= |det| means quotient >= 2^32
	always_ff @(posedge clk) begin
		if (adv_s7) begin
			item_s7.dmag     <= dmag_s6;
			item_s7.singular <= (dmag_s6 == '0) || (dmag_s6 < thr_ext);
			for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
				item_s7.lane[i].rem <= {{(mi3_pkg::DET_W - mi3_pkg::COF_W){1'b0}}, cmag_s6[i]};
				item_s7.lane[i].quo <= '0;
				item_s7.lane[i].neg <= neg_s6[i];
				item_s7.lane[i].ovf <= ({{(mi3_pkg::DET_W - mi3_pkg::COF_W){1'b0}}, cmag_s6[i]}
					>= dmag_s6);
			end
		end
	end

	mi3_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s7),
		.in_ready  (div_ready),
		.in_item   (item_s7),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign inv_r0c0  = res.elem[0];
	assign inv_r0c1  = res.elem[1];
	assign inv_r0c2  = res.elem[2];
	assign inv_r1c0  = res.elem[3];
	assign inv_r1c1  = res.elem[4];
	assign inv_r1c2  = res.elem[5];
	assign inv_r2c0  = res.elem[6];
	assign inv_r2c1  = res.elem[7];
	assign inv_r2c2  = res.elem[8];
	assign singular  = res.singular;
	assign saturated = res.saturated;

`ifndef SYNTHESIS
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty first stage");

	a_s7_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !div_ready |=> valid_s7 && $stable(item_s7))
		else $error("stalled front stage lost its item");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> thr_q == $past(cfg_wdata))
		else $error("threshold write not taken");
`endif

endmodule
